// ===== hw/rtl/gha_pkg.sv =====
// package for the generational handle allocator
// holds sizes, opcode and status codes shared by the top level and its checker
// depends on nothing
`default_nettype none

package gha_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = SLOT_W + 1;
  localparam int unsigned VER_W      = 8;
  localparam int unsigned FIELD_W    = SLOT_W + VER_W;
  localparam int unsigned TDATA_W    = ((FIELD_W + 7) / 8) * 8;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STAT_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_INVALID = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== hw/rtl/generational_handle_allocator_top.sv =====
// generational handle allocator: slot/version handles over a version table and free stack
// both tables sit in synchronous memories inside this module
// depends on gha_pkg
//
//   channel   dir  tdata                          tuser
//   s_axis    in   slot_in[9:0], version_in[17:10] opcode[1:0]
//   m_axis    out  slot_out[9:0], version_out[17:10] status[1:0]
//
// one request at a time: release, check and allocate-from-fresh finish in the lookup state,
// allocate from the free stack goes on to a pop state (stack read, then version table read)
// the result register frees the input side; a stalled output holds the block in its
// last step until the result register can be reloaded
// no clearing pass after reset: version entries at or above the fresh-slot count read as zero
`default_nettype none

module generational_handle_allocator_top
  import gha_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [TDATA_W-1:0] s_axis_tdata,   // slot_in, version_in, zero pad
  input  wire logic [OP_W-1:0]    s_axis_tuser,   // opcode
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [TDATA_W-1:0]      m_axis_tdata,   // slot_out, version_out, zero pad
  output logic [STAT_W-1:0]       m_axis_tuser    // status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_POP
  } state_e;

  state_e              state_q, state_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [VER_W-1:0]    ver_q, ver_d;
  logic [SLOT_W-1:0]   pop_slot_q, pop_slot_d;
  logic [CNT_W-1:0]    fresh_q, fresh_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                out_valid_q, out_valid_d;
  logic [STAT_W-1:0]   out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [VER_W-1:0]    out_ver_q, out_ver_d;

  logic [VER_W-1:0]    tbl_mem [SLOT_COUNT];
  logic [SLOT_W-1:0]   stk_mem [SLOT_COUNT];
  logic [VER_W-1:0]    tbl_rdata_q;
  logic [SLOT_W-1:0]   stk_rdata_q;
  logic [SLOT_W-1:0]   tbl_raddr, tbl_waddr, stk_raddr, stk_waddr, stk_wdata;
  logic [VER_W-1:0]    tbl_wdata;
  logic                tbl_we, stk_we;

  logic                in_acc, out_free, in_range, hit, stack_empty;
  logic [VER_W-1:0]    stored_ver, next_ver;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_range    = ({1'b0, slot_q} < fresh_q);
  assign stored_ver  = in_range ? tbl_rdata_q : '0;
  assign hit         = in_range && (ver_q == tbl_rdata_q);
  assign next_ver    = VER_W'(tbl_rdata_q + 1'b1);
  assign stack_empty = (count_q == '0);
  assign stk_raddr   = count_q[SLOT_W-1:0] - 1'b1;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    slot_d       = slot_q;
    ver_d        = ver_q;
    pop_slot_d   = pop_slot_q;
    fresh_d      = fresh_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_ver_d    = out_ver_q;
    tbl_raddr    = slot_q;
    tbl_we       = 1'b0;
    tbl_waddr    = slot_q;
    tbl_wdata    = next_ver;
    stk_we       = 1'b0;
    stk_waddr    = count_q[SLOT_W-1:0];
    stk_wdata    = slot_q;

    case (state_q)
      ST_IDLE: begin
        tbl_raddr = s_axis_tdata[SLOT_W-1:0];
        if (in_acc) begin
          op_d    = s_axis_tuser;
          slot_d  = s_axis_tdata[SLOT_W-1:0];
          ver_d   = s_axis_tdata[FIELD_W-1:SLOT_W];
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (op_q == OP_ALLOC && !stack_empty) begin
          // second read: version of the popped slot
          tbl_raddr  = stk_rdata_q;
          pop_slot_d = stk_rdata_q;
          state_d    = ST_POP;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_slot_d  = slot_q;
          state_d     = ST_IDLE;
          case (op_q)
            OP_ALLOC: begin
              if (!fresh_q[SLOT_W]) begin
                tbl_we       = 1'b1;
                tbl_waddr    = fresh_q[SLOT_W-1:0];
                tbl_wdata    = VER_W'(1);
                fresh_d      = fresh_q + 1'b1;
                out_status_d = STAT_OK;
                out_slot_d   = fresh_q[SLOT_W-1:0];
                out_ver_d    = VER_W'(1);
              end else begin
                out_status_d = STAT_FULL;
                out_ver_d    = '0;
              end
            end
            OP_RELEASE: begin
              if (hit) begin
                tbl_we       = 1'b1;
                out_status_d = STAT_OK;
                out_ver_d    = next_ver;
                // a wrapped version retires the slot; a full stack drops the push
                if (next_ver != '0 && !count_q[SLOT_W]) begin
                  stk_we  = 1'b1;
                  count_d = count_q + 1'b1;
                end
              end else begin
                out_status_d = STAT_INVALID;
                out_ver_d    = stored_ver;
              end
            end
            OP_CHECK: begin
              out_status_d = hit ? STAT_OK : STAT_INVALID;
              out_ver_d    = stored_ver;
            end
            default: begin
              out_status_d = STAT_INVALID;
              out_ver_d    = '0;
            end
          endcase
        end
      end
      ST_POP: begin
        tbl_raddr = pop_slot_q;
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_slot_d   = pop_slot_q;
          out_ver_d    = tbl_rdata_q;
          count_d      = count_q - 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= '0;
      slot_q       <= '0;
      ver_q        <= '0;
      pop_slot_q   <= '0;
      fresh_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_ver_q    <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      slot_q       <= slot_d;
      ver_q        <= ver_d;
      pop_slot_q   <= pop_slot_d;
      fresh_q      <= fresh_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_ver_q    <= out_ver_d;
    end
  end

  // version table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  // free stack
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(TDATA_W - FIELD_W){1'b0}}, out_ver_q, out_slot_q};

endmodule

`default_nettype wire

// ===== hw/rtl/gha_checker.sv =====
// port-level checker for the generational handle allocator, bound to the top level
// depends on gha_pkg and generational_handle_allocator_top
`default_nettype none

module gha_checker
  import gha_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic [TDATA_W-1:0] s_axis_tdata,
  input wire logic [OP_W-1:0]    s_axis_tuser,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [TDATA_W-1:0] m_axis_tdata,
  input wire logic [STAT_W-1:0]  m_axis_tuser
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one request in flight
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // a result is never raised directly on acceptance of its request
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after request");

  // a waiting request holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("request changed while waiting");

  // pad bits of the result stay zero
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[TDATA_W-1:FIELD_W] == '0))
    else $error("result pad bits set");

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/tb.sv =====
// self-checking bench for generational_handle_allocator_top: drives allocate, release and
// check requests over the stream ports and compares each reply with a shadow of the tables
// depends on gha_pkg and generational_handle_allocator_top
`default_nettype none

module tb;
  import gha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MIX_ITEMS = 250;
  localparam int unsigned TAIL_ITEMS = 200;
  localparam int unsigned LONG_HOLD = 400;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [VER_W-1:0]  version;
  } handle_reply_t;

  class allocator_shadow;
    logic [VER_W-1:0]  version_table [SLOT_COUNT];
    logic [SLOT_W-1:0] free_slots [SLOT_COUNT];
    int unsigned       fresh_count;
    int unsigned       stack_count;
    handle_reply_t     expected_replies [$];
    int unsigned       mismatches;

    function new();
      foreach (version_table[i]) version_table[i] = '0;
      foreach (free_slots[i]) free_slots[i] = '0;
      fresh_count = 0;
      stack_count = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    // applies one accepted request to the shadow tables and queues its reply
    function handle_reply_t predict_reply(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                          logic [VER_W-1:0] ver);
      handle_reply_t r;
      logic issued;
      issued = (slot < fresh_count);
      r.status = STAT_INVALID;
      r.slot = slot;
      r.version = '0;
      case (op)
        OP_ALLOC: begin
          if (stack_count != 0) begin
            stack_count--;
            r.slot = free_slots[stack_count];
            r.version = version_table[r.slot];
            r.status = STAT_OK;
          end else if (fresh_count < SLOT_COUNT) begin
            r.slot = SLOT_W'(fresh_count);
            fresh_count++;
            version_table[r.slot] = VER_W'(1);
            r.version = version_table[r.slot];
            r.status = STAT_OK;
          end else begin
            r.status = STAT_FULL;
          end
        end
        OP_RELEASE: begin
          if (issued && ver == version_table[slot]) begin
            version_table[slot] = version_table[slot] + 1'b1;
            // a wrapped version retires the slot, a full stack drops the push
            if (version_table[slot] != '0 && stack_count < SLOT_COUNT) begin
              free_slots[stack_count] = slot;
              stack_count++;
            end
            r.status = STAT_OK;
          end
          if (issued) r.version = version_table[slot];
        end
        OP_CHECK: begin
          if (issued && ver == version_table[slot]) r.status = STAT_OK;
          if (issued) r.version = version_table[slot];
        end
        default: ;
      endcase
      expected_replies.insert(expected_replies.size(), r);
      return r;
    endfunction

    task check_reply(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] slot,
                     logic [VER_W-1:0] ver);
      handle_reply_t e;
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected reply status=%0d slot=%0d version=%0d",
                         status, slot, ver));
        return;
      end
      e = expected_replies.pop_front();
      if (status !== e.status || slot !== e.slot || ver !== e.version)
        report($sformatf("got status=%0d slot=%0d version=%0d, want %0d %0d %0d",
                         status, slot, ver, e.status, e.slot, e.version));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic [OP_W-1:0]    s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]  m_axis_tuser;

  allocator_shadow    shadow;
  logic [SLOT_W-1:0]  live_slots [$];
  int unsigned        replies_seen = 0;
  bit                 quiet;
  bit                 sender_bursty;
  bit                 receiver_bursty = 1'b1;
  bit                 long_hold_done = 1'b0;

  generational_handle_allocator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned sender_gap();
    if (quiet) return 0;
    if ($urandom_range(0, 39) == 0) sender_bursty = !sender_bursty;
    if (sender_bursty && $urandom_range(0, 3) == 0) return $urandom_range(1, 18);
    return 0;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                              input logic [VER_W-1:0] ver);
    handle_reply_t r;
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(TDATA_W-FIELD_W){1'b0}}, ver, slot};
    s_axis_tuser <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    r = shadow.predict_reply(op, slot, ver);
    if (op == OP_ALLOC && r.status == STAT_OK) live_slots.insert(live_slots.size(), r.slot);
    if (op == OP_RELEASE && r.status == STAT_OK) begin
      for (int i = 0; i < live_slots.size(); i++) begin
        if (live_slots[i] == slot) begin
          live_slots.delete(i);
          break;
        end
      end
    end
    @(negedge clk_i);
  endtask

  task automatic alloc_request();
    send_request(OP_ALLOC, SLOT_W'($urandom), VER_W'($urandom));
  endtask

  // mostly well-formed handle traffic, some stale or forged handles and noise
  task automatic mixed_request();
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [VER_W-1:0]  ver;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    op = OP_ALLOC;
    slot = SLOT_W'($urandom);
    ver = VER_W'($urandom);
    if (pick >= 35 && pick < 72 && live_slots.size() != 0) begin
      slot = live_slots[$urandom_range(0, live_slots.size() - 1)];
      ver = shadow.version_table[slot];
      op = (pick < 60) ? OP_RELEASE : OP_CHECK;
    end else if (pick >= 72 && pick < 80 && shadow.fresh_count != 0) begin
      slot = SLOT_W'($urandom_range(0, shadow.fresh_count - 1));
      ver = $urandom_range(0, 1) ? shadow.version_table[slot] - 1'b1 : VER_W'($urandom);
      op = $urandom_range(0, 1) ? OP_RELEASE : OP_CHECK;
    end else if (pick >= 80 && pick < 86 && shadow.fresh_count != 0) begin
      // release of an issued slot with its current version, free or not
      slot = SLOT_W'($urandom_range(0, shadow.fresh_count - 1));
      ver = shadow.version_table[slot];
      op = OP_RELEASE;
    end else if (pick >= 86 && pick < 96) begin
      op = OP_W'($urandom_range(0, (1 << OP_W) - 1));
    end else if (pick >= 96 && shadow.fresh_count < SLOT_COUNT) begin
      slot = SLOT_W'($urandom_range(shadow.fresh_count, SLOT_COUNT - 1));
      op = $urandom_range(0, 1) ? OP_RELEASE : OP_CHECK;
    end
    send_request(op, slot, ver);
  endtask

  initial begin
    int unsigned stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        stall_left = 0;
      end else if (!long_hold_done && replies_seen >= 120) begin
        // long hold so the block backs up into its input
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        if ($urandom_range(0, 199) == 0) receiver_bursty = !receiver_bursty;
        if (receiver_bursty && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 18);
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      replies_seen++;
      shadow.check_reply(m_axis_tuser, m_axis_tdata[SLOT_W-1:0],
                         m_axis_tdata[FIELD_W-1:SLOT_W]);
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("generational_handle_allocator_top verification failed");
    $finish;
  end

  initial begin
    logic [SLOT_W-1:0] hammer;
    logic [SLOT_W-1:0] s;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ALLOC;
    quiet = 1'b0;
    sender_bursty = 1'b1;
    shadow = new();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty tables, fresh allocation, stale and forged handles, unused code
    send_request(OP_CHECK, '0, '0);
    send_request(OP_RELEASE, SLOT_W'(SLOT_COUNT - 1), '1);
    send_request(OP_UNUSED, SLOT_W'(SLOT_COUNT - 1), '1);
    send_request(OP_ALLOC, SLOT_W'(SLOT_COUNT - 1), '1);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_CHECK, SLOT_W'(0), VER_W'(1));
    send_request(OP_CHECK, SLOT_W'(0), '1);
    send_request(OP_RELEASE, SLOT_W'(0), VER_W'(1));
    send_request(OP_CHECK, SLOT_W'(0), VER_W'(1));
    send_request(OP_RELEASE, SLOT_W'(0), VER_W'(2));
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_RELEASE, SLOT_W'(1), VER_W'(0));
    send_request(OP_CHECK, SLOT_W'(2), VER_W'(1));
    send_request(OP_UNUSED, '0, '0);
    send_request(OP_CHECK, SLOT_W'(3), VER_W'(0));
    send_request(OP_RELEASE, SLOT_W'(1), VER_W'(1));
    send_request(OP_ALLOC, '1, '1);

    repeat (MIX_ITEMS) mixed_request();

    // use up every slot, then ask past the end
    while (shadow.stack_count != 0 || shadow.fresh_count < SLOT_COUNT) begin
      if ($urandom_range(0, 7) == 0 && live_slots.size() != 0) begin
        s = live_slots[$urandom_range(0, live_slots.size() - 1)];
        send_request(OP_CHECK, s, shadow.version_table[s]);
      end else begin
        alloc_request();
      end
    end
    repeat (4) alloc_request();
    send_request(OP_CHECK, '1, shadow.version_table[SLOT_COUNT - 1]);

    // walk one slot through every version until it wraps and retires
    hammer = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
    do begin
      send_request(OP_RELEASE, hammer, shadow.version_table[hammer]);
    end while (shadow.version_table[hammer] != '0);
    send_request(OP_CHECK, hammer, '1);
    send_request(OP_CHECK, hammer, '0);

    quiet = 1'b1;
    repeat (TAIL_ITEMS) mixed_request();
    s_axis_tvalid <= 1'b0;

    while (shadow.expected_replies.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0) begin
      $display("generational_handle_allocator_top verification clean");
    end else begin
      $display("generational_handle_allocator_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
